### rtl/core/sbda_pkg.sv
// Package for the signed binary to decimal ASCII core.
// Holds the sequencer state type and the character constants; no dependencies.
`default_nettype none

package sbda_pkg;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

endpackage

`default_nettype wire

### rtl/core/sbda_dabble_step.sv
// One shift-add-3 step of the binary to BCD conversion.
// Combinational; used by the top level once per clock while in the conversion state. No dependencies.
`default_nettype none

module sbda_dabble_step #(
  parameter int DIGITS = 10,
  parameter int BITS   = 32
) (
  input  wire logic [4*DIGITS-1:0] bcd_in,
  input  wire logic [BITS-1:0]     bin_in,
  output logic      [4*DIGITS-1:0] bcd_out,
  output logic      [BITS-1:0]     bin_out
);

  logic [4*DIGITS-1:0] adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_in[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_in[4*i +: 4];
      end
    end
  end

  assign bcd_out = {adj[4*DIGITS-2:0], bin_in[BITS-1]};
  assign bin_out = {bin_in[BITS-2:0], 1'b0};

endmodule

`default_nettype wire

### rtl/core/signed_binary_to_decimal_ascii_core.sv
// Top level of the signed binary to decimal ASCII converter.
// Depends on sbda_pkg and sbda_dabble_step. busy is high for the whole conversion.
// Sequence: a shift-add-3 step for each value bit, then a scan that drops leading zero digits
// (at least one digit is kept), then one character per strobe, a minus sign first for a
// negative value. A new start is taken only in idle, after the last character is out.
// Reset is synchronous; it returns the sequencer to idle and drops the strobe.
`default_nettype none

module signed_binary_to_decimal_ascii_core #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic      [5:0]            char_code,
  output logic                       last,
  output logic                       strobe
);

  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int CW     = $clog2(VALUE_BITS + 1);
  localparam int NW     = $clog2(DIGITS + 1);

  sbda_pkg::state_t state;

  logic [VALUE_BITS-1:0] bin;
  logic [4*DIGITS-1:0]   bcd;
  logic [CW-1:0]         cnt;
  logic [NW-1:0]         ndig;
  logic                  neg;

  logic [VALUE_BITS-1:0] bin_step;
  logic [4*DIGITS-1:0]   bcd_step;
  logic [3:0]            top;

  sbda_dabble_step #(
    .DIGITS(DIGITS),
    .BITS  (VALUE_BITS)
  ) u_step (
    .bcd_in (bcd),
    .bin_in (bin),
    .bcd_out(bcd_step),
    .bin_out(bin_step)
  );

  assign top  = bcd[4*DIGITS-1 -: 4];
  assign busy = (state != sbda_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sbda_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        sbda_pkg::ST_IDLE: begin
          if (start) begin
            neg   <= value[VALUE_BITS-1];
            bin   <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
            bcd   <= '0;
            cnt   <= CW'(VALUE_BITS);
            ndig  <= NW'(DIGITS);
            state <= sbda_pkg::ST_CONV;
          end
        end
        sbda_pkg::ST_CONV: begin
          bcd <= bcd_step;
          bin <= bin_step;
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            state <= sbda_pkg::ST_SCAN;
          end
        end
        sbda_pkg::ST_SCAN: begin
          if ((top == 4'd0) && (ndig != NW'(1))) begin
            bcd  <= {bcd[4*DIGITS-5:0], 4'd0};
            ndig <= ndig - 1'b1;
          end else begin
            state <= sbda_pkg::ST_EMIT;
          end
        end
        sbda_pkg::ST_EMIT: begin
          strobe <= 1'b1;
          if (neg) begin
            char_code <= sbda_pkg::CHAR_MINUS;
            last      <= 1'b0;
            neg       <= 1'b0;
          end else begin
            char_code <= sbda_pkg::CHAR_ZERO + {2'b00, top};
            last      <= (ndig == NW'(1));
            bcd       <= {bcd[4*DIGITS-5:0], 4'd0};
            ndig      <= ndig - 1'b1;
            if (ndig == NW'(1)) begin
              state <= sbda_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state <= sbda_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
